@@ src/tpid_pkg.sv @@
// Shared widths, register codes and types for the three-axis PID unit.
package tpid_pkg;

  localparam int MX_W      = 13;
  localparam int POS_W     = 24;
  localparam int FRC_W     = 29;
  localparam int SCR_W     = 14;
  localparam int GAIN_W    = 27;
  localparam int LIM_W     = 25;
  localparam int ZT_W      = 24;
  localparam int FMAX_W    = 28;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 28;

  localparam int TGT_W  = 32;
  localparam int INT_W  = 26;
  localparam int ERR_W  = 33;
  localparam int DPOS_W = 25;

  localparam int DIV_STEPS = 20;
  localparam int DIV_CNT_W = 5;
  localparam int DIV_MAG_W = 2 * DIV_STEPS;
  localparam int DIV_NUM_W = DIV_MAG_W + 1;
  localparam int DIV_DEN_W = 18;

  localparam int MAC_TERMS   = 3;
  localparam int MAC_CHUNK_W = 18;
  localparam int MAC_MAG_W   = 2 * MAC_CHUNK_W;
  localparam int MAC_PROD_W  = GAIN_W + MAC_CHUNK_W;
  localparam int MAC_IDX_W   = 3;
  localparam int ACC_W       = 66;

  localparam logic [DIV_DEN_W-1:0] DEN_TEN = DIV_DEN_W'(10);
  localparam logic [DIV_DEN_W-1:0] DEN_MS  = DIV_DEN_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH   = 4'd0,
    REG_SCREEN_HEIGHT  = 4'd1,
    REG_KP             = 4'd2,
    REG_KI             = 4'd3,
    REG_KD             = 4'd4,
    REG_INTEGRAL_LIMIT = 4'd5,
    REG_Z_TARGET       = 4'd6,
    REG_MAX_FORCE      = 4'd7
  } reg_idx_t;

  localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH   = SCR_W'(1920);
  localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT  = SCR_W'(1080);
  localparam logic [GAIN_W-1:0] RST_KP             = GAIN_W'(6553600);
  localparam logic [GAIN_W-1:0] RST_KI             = GAIN_W'(327680);
  localparam logic [GAIN_W-1:0] RST_KD             = GAIN_W'(524288);
  localparam logic [LIM_W-1:0]  RST_INTEGRAL_LIMIT = LIM_W'(83886);
  localparam logic [ZT_W-1:0]   RST_Z_TARGET       = ZT_W'(1677722);
  localparam logic [FMAX_W-1:0] RST_MAX_FORCE      = FMAX_W'(33554432);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    gain;
    logic [MAC_MAG_W-1:0] mag;
    logic                 neg;
  } mac_term_t;

endpackage

@@ src/tpid_in_if.sv @@
// Input word channel: cursor and measured grip position.
interface tpid_in_if;
  import tpid_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MX_W-1:0]         mouse_x;
  logic [MX_W-1:0]         mouse_y;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source (output valid, mouse_x, mouse_y, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, mouse_x, mouse_y, pos_x, pos_y, pos_z, output ready);
endinterface

@@ src/tpid_out_if.sv @@
// Output word channel: three saturated drive forces.
interface tpid_out_if;
  import tpid_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [FRC_W-1:0] force_x;
  logic signed [FRC_W-1:0] force_y;
  logic signed [FRC_W-1:0] force_z;
  modport source (output valid, force_x, force_y, force_z, input ready);
  modport sink (input valid, force_x, force_y, force_z, output ready);
endinterface

@@ src/tpid_cfg_if.sv @@
// Configuration write channel: register index and data.
interface tpid_cfg_if;
  import tpid_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/tpid_div.sv @@
// Iterative signed divider, rounds to nearest with ties away from zero, two bits a cycle.
module tpid_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tpid_pkg::div_req_t                     req,
  output logic                                   done,
  output logic signed [tpid_pkg::DIV_NUM_W-1:0]  quo
);
  import tpid_pkg::*;

  logic                        run;
  logic [DIV_CNT_W-1:0]        cnt;
  logic                        neg;
  logic [DIV_MAG_W-1:0]        mag;
  logic [DIV_DEN_W-1:0]        rem;
  logic [DIV_DEN_W-1:0]        den_q;

  logic signed [DIV_NUM_W-1:0] num_s;
  logic [DIV_NUM_W-1:0]        num_abs;
  logic [DIV_MAG_W-1:0]        mag_load;
  logic [DIV_DEN_W:0]          r1, r2, diff1, diff2;
  logic                        b1, b2;
  logic [DIV_DEN_W-1:0]        rem1, rem2;

  always_comb begin
    num_s    = $signed(req.num);
    num_abs  = num_s[DIV_NUM_W-1] ? DIV_NUM_W'(-num_s) : DIV_NUM_W'(num_s);
    // bias by half the divisor so truncation rounds to nearest
    mag_load = num_abs[DIV_MAG_W-1:0]
             + {{(DIV_MAG_W-DIV_DEN_W+1){1'b0}}, req.den[DIV_DEN_W-1:1]};
    r1    = {rem, mag[DIV_MAG_W-1]};
    diff1 = r1 - {1'b0, den_q};
    b1    = (r1 >= {1'b0, den_q});
    rem1  = b1 ? diff1[DIV_DEN_W-1:0] : r1[DIV_DEN_W-1:0];
    r2    = {rem1, mag[DIV_MAG_W-2]};
    diff2 = r2 - {1'b0, den_q};
    b2    = (r2 >= {1'b0, den_q});
    rem2  = b2 ? diff2[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
  end

  assign quo = neg ? DIV_NUM_W'(-$signed({1'b0, mag})) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && run && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift into the low end of mag as the dividend leaves the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      mag   <= mag_load;
      rem   <= '0;
      den_q <= req.den;
      neg   <= req.num[DIV_NUM_W-1];
    end else if (run) begin
      mag <= {mag[DIV_MAG_W-3:0], b1, b2};
      rem <= rem2;
    end
  end

endmodule

@@ src/tpid_mac.sv @@
// Shared multiply-accumulate: sum of three signed gain products, one 27x18 partial a cycle.
module tpid_mac (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  tpid_pkg::mac_term_t [tpid_pkg::MAC_TERMS-1:0] terms,
  output logic                                       done,
  output logic signed [tpid_pkg::ACC_W-1:0]          acc
);
  import tpid_pkg::*;

  mac_term_t [MAC_TERMS-1:0] terms_q;
  logic [MAC_IDX_W-1:0]      idx;
  logic                      run;
  logic                      pv;
  logic                      psh;
  logic                      pneg;
  logic [MAC_PROD_W-1:0]     preg;

  mac_term_t                 cur;
  logic [MAC_CHUNK_W-1:0]    chunk;
  logic [ACC_W-1:0]          tv;

  always_comb begin
    cur   = terms_q[idx[MAC_IDX_W-1:1]];
    chunk = idx[0] ? cur.mag[MAC_MAG_W-1:MAC_CHUNK_W] : cur.mag[MAC_CHUNK_W-1:0];
    tv    = psh ? {{(ACC_W-MAC_PROD_W-MAC_CHUNK_W){1'b0}}, preg, {MAC_CHUNK_W{1'b0}}}
                : {{(ACC_W-MAC_PROD_W){1'b0}}, preg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= pv && !run;
      pv   <= run;
      if (start) begin
        run <= 1'b1;
        idx <= '0;
      end else if (run) begin
        idx <= idx + 1'b1;
        if (idx == MAC_IDX_W'(2 * MAC_TERMS - 1)) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      terms_q <= terms;
      acc     <= '0;
    end else begin
      if (run) begin
        preg <= cur.gain * chunk;
        psh  <= idx[0];
        pneg <= cur.neg;
      end
      if (pv) acc <= pneg ? acc - $signed(tv) : acc + $signed(tv);
    end
  end

endmodule

@@ src/three_axis_pid_with_filtered_target_unit.sv @@
// Three-axis PID with low-pass cursor target, on a shared divider and multiplier.
// Sequence: each word takes seven divides
//   (cursor map, filter and integrator steps) and three multiply-accumulate passes.
// Flow: ready is high only in the idle state, so a new word waits until the last is done; the
//   result register lets the next word in while the last result waits.
// Reset (rst, synchronous): registers to defaults, filters, integrators and last positions to zero.
module three_axis_pid_with_filtered_target_unit (
  input logic         clk,
  input logic         rst,
  tpid_in_if.sink     meas,
  tpid_out_if.source  drive,
  tpid_cfg_if.sink    cfg
);
  import tpid_pkg::*;

  localparam int AXES   = 3;
  localparam int AXIS_W = 2;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_TX   = 10'b00_0000_0010,
    S_FX   = 10'b00_0000_0100,
    S_TY   = 10'b00_0000_1000,
    S_FY   = 10'b00_0001_0000,
    S_PREP = 10'b00_0010_0000,
    S_INT  = 10'b00_0100_0000,
    S_MAC  = 10'b00_1000_0000,
    S_FRC  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  // configuration
  logic [SCR_W-1:0]       screen_width, screen_height;
  logic [GAIN_W-1:0]      kp, ki, kd;
  logic [LIM_W-1:0]       integral_limit;
  logic signed [ZT_W-1:0] z_target;
  logic [FMAX_W-1:0]      max_force;

  state_t                  state;
  logic                    kick;
  logic [AXIS_W-1:0]       axis;
  logic [MX_W-1:0]         mx, my;
  logic signed [POS_W-1:0] pos [AXES];
  logic signed [POS_W-1:0] last [AXES];
  logic signed [INT_W-1:0] integ [AXES];
  logic signed [FRC_W-1:0] force_q [AXES];
  logic signed [TGT_W-1:0] filt_x, filt_y, tgt;
  logic signed [ERR_W-1:0] e_q;
  logic signed [DPOS_W-1:0] d_q;

  div_req_t                      div_req;
  logic                          div_done;
  logic signed [DIV_NUM_W-1:0]   quo;
  logic                          mac_start, mac_done;
  mac_term_t [MAC_TERMS-1:0]     terms;
  logic signed [ACC_W-1:0]       acc;

  logic                          accept;
  logic [SCR_W-1:0]              w_eff, h_eff;
  logic signed [DIV_NUM_W-1:0]   n_tx, n_ty, n_fx, n_fy;
  logic [DIV_DEN_W-1:0]          den_tx, den_ty;
  logic signed [TGT_W-1:0]       tgt_sat;
  logic signed [ERR_W-1:0]       sp, e_val;
  logic signed [DPOS_W-1:0]      d_val;
  logic signed [INT_W:0]         isum, lim_s;
  logic signed [INT_W-1:0]       integ_new;
  logic [ERR_W-1:0]              e_mag;
  logic [INT_W-1:0]              i_mag;
  logic [DPOS_W-1:0]             d_mag;
  logic [MAC_MAG_W-1:0]          v_mag;
  logic [ACC_W-1:0]              a_mag, a_rnd;
  logic [ACC_W-17:0]             a_q;
  logic [FMAX_W-1:0]             f_mag;
  logic signed [FRC_W-1:0]       force_val;

  assign cfg.ready  = 1'b1;
  assign meas.ready = (state == S_IDLE);
  assign accept     = meas.valid && meas.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= RST_SCREEN_WIDTH;
      screen_height  <= RST_SCREEN_HEIGHT;
      kp             <= RST_KP;
      ki             <= RST_KI;
      kd             <= RST_KD;
      integral_limit <= RST_INTEGRAL_LIMIT;
      z_target       <= RST_Z_TARGET;
      max_force      <= RST_MAX_FORCE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCREEN_WIDTH:   screen_width   <= cfg.data[SCR_W-1:0];
        REG_SCREEN_HEIGHT:  screen_height  <= cfg.data[SCR_W-1:0];
        REG_KP:             kp             <= cfg.data[GAIN_W-1:0];
        REG_KI:             ki             <= cfg.data[GAIN_W-1:0];
        REG_KD:             kd             <= cfg.data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg.data[LIM_W-1:0];
        REG_Z_TARGET:       z_target       <= cfg.data[ZT_W-1:0];
        REG_MAX_FORCE:      max_force      <= cfg.data[FMAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff  = (screen_width == '0) ? SCR_W'(1) : screen_width;
    h_eff  = (screen_height == '0) ? SCR_W'(1) : screen_height;
    den_tx = DIV_DEN_W'({w_eff, 3'b000}) + DIV_DEN_W'({w_eff, 1'b0});
    den_ty = DIV_DEN_W'({h_eff, 3'b000}) + DIV_DEN_W'({h_eff, 1'b0});
    n_tx   = $signed(DIV_NUM_W'({mx, 24'b0})) - $signed(DIV_NUM_W'({w_eff, 23'b0}));
    n_ty   = $signed(DIV_NUM_W'({h_eff, 23'b0})) - $signed(DIV_NUM_W'({my, 24'b0}));
    n_fx   = DIV_NUM_W'(tgt) - DIV_NUM_W'(filt_x);
    n_fy   = DIV_NUM_W'(tgt) - DIV_NUM_W'(filt_y);

    // saturate the mapped target to 32 bits
    if ((&quo[DIV_NUM_W-1:TGT_W-1]) || !(|quo[DIV_NUM_W-1:TGT_W-1]))
      tgt_sat = quo[TGT_W-1:0];
    else if (quo[DIV_NUM_W-1])
      tgt_sat = {1'b1, {(TGT_W-1){1'b0}}};
    else
      tgt_sat = {1'b0, {(TGT_W-1){1'b1}}};

    case (axis)
      2'd0:    sp = ERR_W'(filt_x);
      2'd1:    sp = ERR_W'(filt_y);
      default: sp = ERR_W'(z_target);
    endcase
    e_val = sp - ERR_W'(pos[axis]);
    d_val = DPOS_W'(pos[axis]) - DPOS_W'(last[axis]);

    isum  = (INT_W+1)'(integ[axis]) + quo[INT_W:0];
    lim_s = $signed({2'b00, integral_limit});
    if (isum > lim_s)       integ_new = INT_W'(lim_s);
    else if (isum < -lim_s) integ_new = INT_W'(-lim_s);
    else                    integ_new = INT_W'(isum);

    e_mag = e_q[ERR_W-1] ? ERR_W'(-e_q) : ERR_W'(e_q);
    i_mag = integ[axis][INT_W-1] ? INT_W'(-integ[axis]) : INT_W'(integ[axis]);
    d_mag = d_q[DPOS_W-1] ? DPOS_W'(-d_q) : DPOS_W'(d_q);
    // |d| * 1000 = |d|*1024 - |d|*16 - |d|*8
    v_mag = (MAC_MAG_W'(d_mag) << 10) - (MAC_MAG_W'(d_mag) << 4) - (MAC_MAG_W'(d_mag) << 3);

    terms[0] = '{gain: kp, mag: MAC_MAG_W'(e_mag), neg: e_q[ERR_W-1]};
    terms[1] = '{gain: ki, mag: MAC_MAG_W'(i_mag), neg: integ[axis][INT_W-1]};
    terms[2] = '{gain: kd, mag: v_mag, neg: !d_q[DPOS_W-1]};

    a_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    a_rnd = a_mag + ACC_W'(32768);
    a_q   = a_rnd[ACC_W-1:16];
    f_mag = (a_q > (ACC_W-16)'(max_force)) ? max_force : a_q[FMAX_W-1:0];
    force_val = acc[ACC_W-1] ? -$signed(FRC_W'(f_mag)) : $signed(FRC_W'(f_mag));

    div_req.start = kick && (state == S_TX || state == S_FX || state == S_TY ||
                             state == S_FY || state == S_INT);
    unique case (state)
      S_TX:  begin div_req.num = n_tx; div_req.den = den_tx;  end
      S_TY:  begin div_req.num = n_ty; div_req.den = den_ty;  end
      S_FX:  begin div_req.num = n_fx; div_req.den = DEN_TEN; end
      S_FY:  begin div_req.num = n_fy; div_req.den = DEN_TEN; end
      S_INT: begin div_req.num = DIV_NUM_W'(e_q); div_req.den = DEN_MS; end
      default: begin div_req.num = '0; div_req.den = DEN_TEN; end
    endcase
    mac_start = kick && (state == S_MAC);
  end

  tpid_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  tpid_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .terms (terms),
    .done  (mac_done),
    .acc   (acc)
  );

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kick        <= 1'b0;
      axis        <= '0;
      drive.valid <= 1'b0;
      filt_x      <= '0;
      filt_y      <= '0;
      for (int i = 0; i < AXES; i++) begin
        integ[i] <= '0;
        last[i]  <= '0;
      end
    end else begin
      // one-cycle start pulse on entry to each divide or multiply step
      kick <= (state == S_IDLE && accept) || (state == S_PREP) ||
              (div_done && (state == S_TX || state == S_FX || state == S_TY ||
                            state == S_INT));
      if (drive.valid && drive.ready && state != S_DONE) drive.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          state <= S_TX;
        end
        S_TX: if (div_done) begin
          state <= S_FX;
        end
        S_FX: if (div_done) begin
          filt_x <= filt_x + quo[TGT_W-1:0];
          state  <= S_TY;
        end
        S_TY: if (div_done) begin
          state <= S_FY;
        end
        S_FY: if (div_done) begin
          filt_y <= filt_y + quo[TGT_W-1:0];
          axis   <= '0;
          state  <= S_PREP;
        end
        S_PREP: begin
          state <= S_INT;
        end
        S_INT: if (div_done) begin
          integ[axis] <= integ_new;
          state       <= S_MAC;
        end
        S_MAC: if (mac_done) state <= S_FRC;
        S_FRC: begin
          last[axis] <= pos[axis];
          if (axis == AXIS_W'(AXES - 1)) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_PREP;
          end
        end
        S_DONE: if (!drive.valid || drive.ready) begin
          drive.valid <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (accept) begin
      mx     <= meas.mouse_x;
      my     <= meas.mouse_y;
      pos[0] <= meas.pos_x;
      pos[1] <= meas.pos_y;
      pos[2] <= meas.pos_z;
    end
    if ((state == S_TX || state == S_TY) && div_done) tgt <= tgt_sat;
    if (state == S_PREP) begin
      e_q <= e_val;
      d_q <= d_val;
    end
    if (state == S_FRC) force_q[axis] <= force_val;
    if (state == S_DONE && (!drive.valid || drive.ready)) begin
      drive.force_x <= force_q[0];
      drive.force_y <= force_q[1];
      drive.force_z <= force_q[2];
    end
  end

`ifndef ASSERT_OFF
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TX || state == S_FX || state == S_TY ||
                  state == S_FY || state == S_INT))
    else $error("divider finished outside a divide step");

  a_mac_done_state: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_MAC))
    else $error("multiply-accumulate finished outside its step");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(drive.valid) |-> $past(state == S_DONE))
    else $error("result word raised without a finished tick");
`endif

endmodule

@@ sim/tb_three_axis_pid_with_filtered_target_unit.sv @@
// Testbench for the three-axis PID unit: directed table, random ticks, predicted forces.
module tb_three_axis_pid_with_filtered_target_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tpid_pkg::*;

  localparam int N_RANDOM   = 480;
  localparam int CYC_LIMIT  = 400000;
  localparam int LONG_STALL = 1500;

  typedef struct {
    logic [MX_W-1:0]  mx;
    logic [MX_W-1:0]  my;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
  } tick_t;

  typedef struct {
    logic [FRC_W-1:0] fx;
    logic [FRC_W-1:0] fy;
    logic [FRC_W-1:0] fz;
  } force_t;

  typedef struct {
    tick_t  t;
    bit     known;  // expected forces typed in below
    force_t f;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  tpid_in_if  meas();
  tpid_out_if drive();
  tpid_cfg_if cfg();

  three_axis_pid_with_filtered_target_unit dut (
    .clk(clk), .rst(rst), .meas(meas), .drive(drive), .cfg(cfg)
  );

  // predictor state
  longint unsigned regs[8];
  longint filt_x, filt_y, integ_x, integ_y, integ_z, last_x, last_y, last_z;

  force_t expected_forces[$];
  int mismatches = 0;
  int forces_seen = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  function automatic longint rnd_div(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint axis_force(longint sp, longint pos, ref longint last,
                                        ref longint integ);
    longint lim, e, v, acc;
    lim = regs[REG_INTEGRAL_LIMIT];
    e = sp - pos;
    v = (pos - last) * 1000;
    integ = clip(integ + rnd_div(e, 1000), -lim, lim);
    acc = longint'(regs[REG_KP]) * e + longint'(regs[REG_KI]) * integ
        - longint'(regs[REG_KD]) * v;
    last = pos;
    return clip(rnd_div(acc, 65536), -longint'(regs[REG_MAX_FORCE]),
                longint'(regs[REG_MAX_FORCE]));
  endfunction

  function automatic force_t pid_tick(tick_t t);
    longint unsigned w, h;
    longint tx, ty, zt;
    force_t f;
    w = regs[REG_SCREEN_WIDTH] ? regs[REG_SCREEN_WIDTH] : 1;
    h = regs[REG_SCREEN_HEIGHT] ? regs[REG_SCREEN_HEIGHT] : 1;
    zt = longint'(signed'(regs[REG_Z_TARGET][ZT_W-1:0]));
    tx = rnd_div(longint'(t.mx) * 16777216 - longint'(w) * 8388608, 10 * w);
    ty = rnd_div(longint'(h) * 8388608 - longint'(t.my) * 16777216, 10 * h);
    tx = clip(tx, -64'sd2147483648, 64'sd2147483647);
    ty = clip(ty, -64'sd2147483648, 64'sd2147483647);
    filt_x += rnd_div(tx - filt_x, 10);
    filt_y += rnd_div(ty - filt_y, 10);
    f.fx = FRC_W'(axis_force(filt_x, longint'(signed'(t.px)), last_x, integ_x));
    f.fy = FRC_W'(axis_force(filt_y, longint'(signed'(t.py)), last_y, integ_y));
    f.fz = FRC_W'(axis_force(zt, longint'(signed'(t.pz)), last_z, integ_z));
    return f;
  endfunction

  task automatic write_reg(reg_idx_t idx, longint unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg.ready);
    regs[idx] = val & ((64'd1 << CFG_DATA_W) - 1);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Unknown index: must change nothing.
  task automatic write_bogus();
    cfg.valid <= 1'b1;
    cfg.index <= CFG_IDX_W'(8 + $urandom_range(0, 7));
    cfg.data  <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (expected_forces.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic send_tick(tick_t t, bit known, force_t kf);
    force_t f;
    meas.valid   <= 1'b1;
    meas.mouse_x <= t.mx;
    meas.mouse_y <= t.my;
    meas.pos_x   <= t.px;
    meas.pos_y   <= t.py;
    meas.pos_z   <= t.pz;
    do @(posedge clk); while (!meas.ready);
    f = pid_tick(t);
    if (known && (f.fx != kf.fx || f.fy != kf.fy || f.fz != kf.fz)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: exp %h %h %h got %h %h %h",
                 kf.fx, kf.fy, kf.fz, f.fx, f.fy, f.fz);
    end
    expected_forces.push_back(f);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    meas.valid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return POS_W'(24'sd4194304);
      1: return POS_W'(-24'sd4194304);
      2: return POS_W'($urandom);
      default: return POS_W'($urandom_range(0, 400000) - 200000);
    endcase
  endfunction

  task automatic random_ticks(int n);
    tick_t t;
    force_t none;
    int burst;
    burst = 0;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) idle_gap();
      end
      burst--;
      t.mx = MX_W'($urandom);
      t.my = MX_W'($urandom);
      t.px = rand_pos();
      t.py = rand_pos();
      t.pz = rand_pos();
      send_tick(t, 1'b0, none);
    end
    meas.valid <= 1'b0;
  endtask

  // Receiver: own stall pattern, plus one long hold-off.
  initial begin
    drive.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) drive.ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) drive.ready <= 1'($urandom_range(0, 1));
      else drive.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  always @(posedge clk) begin
    force_t e;
    if (!rst && drive.valid && drive.ready) begin
      forces_seen++;
      if (expected_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("force word with none expected");
      end else begin
        e = expected_forces.pop_front();
        if (drive.force_x !== e.fx || drive.force_y !== e.fy || drive.force_z !== e.fz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("force mismatch: exp %h %h %h got %h %h %h", e.fx, e.fy, e.fz,
                     drive.force_x, drive.force_y, drive.force_z);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_three_axis_pid_with_filtered_target_unit NOT OK");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    force_t zf;
    zf = '{default: '0};
    meas.valid = 1'b0; meas.mouse_x = '0; meas.mouse_y = '0;
    meas.pos_x = '0; meas.pos_y = '0; meas.pos_z = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    regs = '{RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_KP, RST_KI, RST_KD,
             RST_INTEGRAL_LIMIT, RST_Z_TARGET, RST_MAX_FORCE};
    filt_x = 0; filt_y = 0; integ_x = 0; integ_y = 0; integ_z = 0;
    last_x = 0; last_y = 0; last_z = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table at reset settings: extremes of cursor and grip position.
    dir_rows = '{
      '{'{13'd960, 13'd540, 24'd0, 24'd0, 24'd1677722}, 1'b0, zf},
      '{'{13'd0, 13'd0, 24'd0, 24'd0, 24'd0}, 1'b0, zf},
      '{'{13'd8191, 13'd8191, 24'h400000, 24'hC00000, 24'h400000}, 1'b0, zf},
      '{'{13'd1919, 13'd1079, 24'hC00000, 24'h400000, 24'hC00000}, 1'b0, zf},
      '{'{13'd1, 13'd8191, 24'h7FFFFF, 24'h800000, 24'hFFFFFF}, 1'b0, zf},
      '{'{13'd4096, 13'd2, 24'h000001, 24'h555555, 24'hAAAAAA}, 1'b0, zf}
    };
    foreach (dir_rows[i]) send_tick(dir_rows[i].t, dir_rows[i].known, dir_rows[i].f);
    meas.valid <= 1'b0;
    drain();

    // Zero limits: integrators held, every force zero.
    write_reg(REG_MAX_FORCE, 0);
    write_reg(REG_INTEGRAL_LIMIT, 0);
    write_bogus();
    send_tick('{13'd8191, 13'd0, 24'h400000, 24'hC00000, 24'h400000}, 1'b1, zf);
    send_tick('{13'd0, 13'd8191, 24'hC00000, 24'h400000, 24'hC00000}, 1'b1, zf);
    meas.valid <= 1'b0;
    drain();

    // Zero screen size and extreme gains.
    write_reg(REG_SCREEN_WIDTH, 0);
    write_reg(REG_SCREEN_HEIGHT, 0);
    write_reg(REG_KP, 67108864);
    write_reg(REG_KI, 67108864);
    write_reg(REG_KD, 67108864);
    write_reg(REG_INTEGRAL_LIMIT, 16777216);
    write_reg(REG_MAX_FORCE, 134217728);
    write_reg(REG_Z_TARGET, 24'hC00000);
    random_ticks(20);
    drain();

    write_reg(REG_SCREEN_WIDTH, 8192);
    write_reg(REG_SCREEN_HEIGHT, 8192);
    write_reg(REG_KP, 0);
    write_reg(REG_KI, 0);
    write_reg(REG_KD, 0);
    write_reg(REG_Z_TARGET, 24'h400000);
    random_ticks(10);
    drain();

    // Back to everyday settings; long receiver hold-off under full offer.
    write_reg(REG_SCREEN_WIDTH, 1920);
    write_reg(REG_SCREEN_HEIGHT, 1080);
    write_reg(REG_KP, RST_KP);
    write_reg(REG_KI, RST_KI);
    write_reg(REG_KD, RST_KD);
    write_reg(REG_INTEGRAL_LIMIT, RST_INTEGRAL_LIMIT);
    write_reg(REG_Z_TARGET, RST_Z_TARGET);
    write_reg(REG_MAX_FORCE, RST_MAX_FORCE);
    fork
      begin
        hold_off = 1'b1;
        repeat (LONG_STALL) @(negedge clk);
        hold_off = 1'b0;
      end
      random_ticks(N_RANDOM / 2);
    join
    drain();

    for (int k = 0; k < 4; k++) begin
      write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 8192));
      write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 8192));
      write_reg(REG_KP, $urandom_range(0, 67108864));
      write_reg(REG_KI, $urandom_range(0, 67108864));
      write_reg(REG_KD, $urandom_range(0, 67108864));
      write_reg(REG_INTEGRAL_LIMIT, $urandom_range(0, 16777216));
      write_reg(REG_Z_TARGET, ZT_W'($urandom_range(0, 8388608) - 4194304));
      write_reg(REG_MAX_FORCE, $urandom_range(0, 134217728));
      random_ticks(N_RANDOM / 8);
      drain();
    end

    $display("covered %0d force words over reset, zero-limit, extreme and random settings",
             forces_seen);
    $display("including a long output stall and unknown register writes");
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("tb_three_axis_pid_with_filtered_target_unit OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_three_axis_pid_with_filtered_target_unit NOT OK");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/tpid_pkg.sv
src/tpid_in_if.sv
src/tpid_out_if.sv
src/tpid_cfg_if.sv
src/tpid_div.sv
src/tpid_mac.sv
src/three_axis_pid_with_filtered_target_unit.sv
sim/tb_three_axis_pid_with_filtered_target_unit.sv
